// ----- rtl/frq_pkg.sv -----
// Shared constants, codes and types for the frame record/replay queue.
package frq_pkg;

  localparam int MAX_FRAMES       = 64;
  localparam int MAX_FRAME_PIXELS = 4096;
  localparam int PIXEL_BITS       = 24;

  localparam int SLOT_BITS = $clog2(MAX_FRAMES);
  localparam int POS_BITS  = $clog2(MAX_FRAME_PIXELS);
  localparam int ADDR_BITS = SLOT_BITS + POS_BITS;
  localparam int HELD_BITS = 7;
  localparam int LEN_BITS  = 13;
  localparam int CFG_BITS  = 13;

  localparam logic [HELD_BITS-1:0] CAP_RESET = HELD_BITS'(50);
  localparam logic [LEN_BITS-1:0]  LEN_RESET = LEN_BITS'(MAX_FRAME_PIXELS);

  // register indexes
  localparam logic REG_CAPACITY     = 1'b0;
  localparam logic REG_FRAME_PIXELS = 1'b1;

  // frame modes
  localparam logic [1:0] MODE_PASS   = 2'd0;
  localparam logic [1:0] MODE_RECORD = 2'd1;
  localparam logic [1:0] MODE_REPLAY = 2'd2;

  // per-pixel decision from the frame control
  typedef struct packed {
    logic [1:0]           mode;
    logic                 overflow;
    logic [HELD_BITS-1:0] frames_held;
    logic                 flag_missing;
    logic                 end_of_frame;
    logic [ADDR_BITS-1:0] addr;
  } frq_item_t;

endpackage

// ----- rtl/frq_store.sv -----
// Single-port frame store: one slot of frame pixels per ring entry, registered read.
module frq_store (
  input  logic                         clk,
  input  logic                         en,
  input  logic                         we,
  input  logic [frq_pkg::ADDR_BITS-1:0]  addr,
  input  logic [frq_pkg::PIXEL_BITS-1:0] wdata,
  output logic [frq_pkg::PIXEL_BITS-1:0] rdata
);

  localparam int DEPTH = frq_pkg::MAX_FRAMES * frq_pkg::MAX_FRAME_PIXELS;

  logic [frq_pkg::PIXEL_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ----- rtl/frq_ctrl.sv -----
// Frame control: config registers, frame mode decision, ring pointers and pixel position.
module frq_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic                            cfg_index,
  input  logic [frq_pkg::CFG_BITS-1:0]    cfg_wdata,
  input  logic                            accept,
  input  logic                            record_flag,
  input  logic                            flag_present,
  output frq_pkg::frq_item_t              item
);

  logic [frq_pkg::HELD_BITS-1:0] capacity_frames;
  logic [frq_pkg::LEN_BITS-1:0]  frame_pixels;
  logic [frq_pkg::SLOT_BITS-1:0] oldest_slot, oldest_slot_next;
  logic [frq_pkg::HELD_BITS-1:0] frames_held, frames_held_next;
  logic [frq_pkg::POS_BITS-1:0]  pixel_position, pixel_position_next;
  logic [1:0]                    frame_mode;
  logic                          ovf_latched, missing_latched;
  logic [frq_pkg::HELD_BITS-1:0] held_after;
  logic [frq_pkg::SLOT_BITS-1:0] write_slot;

  logic                          start;
  logic [frq_pkg::HELD_BITS-1:0] cap;
  logic [frq_pkg::LEN_BITS-1:0]  len;
  logic [1:0]                    s_mode, mode;
  logic                          s_ovf, s_miss, ovf, miss;
  logic [frq_pkg::HELD_BITS-1:0] s_held, held_now;
  logic [frq_pkg::SLOT_BITS-1:0] s_wslot, wslot;
  logic                          last;
  logic [frq_pkg::LEN_BITS-1:0]  pos_plus;

  always_comb begin
    cap = capacity_frames;
    if (capacity_frames > frq_pkg::HELD_BITS'(frq_pkg::MAX_FRAMES)) begin
      cap = frq_pkg::HELD_BITS'(frq_pkg::MAX_FRAMES);
    end
    len = frame_pixels;
    if (frame_pixels == '0) begin
      len = frq_pkg::LEN_BITS'(1);
    end else if (frame_pixels > frq_pkg::LEN_BITS'(frq_pkg::MAX_FRAME_PIXELS)) begin
      len = frq_pkg::LEN_BITS'(frq_pkg::MAX_FRAME_PIXELS);
    end
  end

  // decision taken at the first pixel of a frame
  always_comb begin
    s_mode  = frq_pkg::MODE_PASS;
    s_ovf   = 1'b0;
    s_miss  = 1'b0;
    s_held  = frames_held;
    s_wslot = frq_pkg::SLOT_BITS'(oldest_slot + frames_held[frq_pkg::SLOT_BITS-1:0]);
    if (!flag_present) begin
      s_miss = 1'b1;
    end else if (record_flag) begin
      if (cap == '0) begin
        s_ovf = 1'b1;
      end else if (frames_held < cap) begin
        s_mode = frq_pkg::MODE_RECORD;
        s_held = frames_held + frq_pkg::HELD_BITS'(1);
      end else begin
        // ring full: append at the tail, drop the oldest at frame end
        s_mode = frq_pkg::MODE_RECORD;
        s_ovf  = 1'b1;
      end
    end else if (frames_held != '0) begin
      s_mode = frq_pkg::MODE_REPLAY;
      s_held = frames_held - frq_pkg::HELD_BITS'(1);
    end
  end

  assign start    = (pixel_position == '0);
  assign mode     = start ? s_mode  : frame_mode;
  assign ovf      = start ? s_ovf   : ovf_latched;
  assign miss     = start ? s_miss  : missing_latched;
  assign held_now = start ? s_held  : held_after;
  assign wslot    = start ? s_wslot : write_slot;
  assign pos_plus = {1'b0, pixel_position} + frq_pkg::LEN_BITS'(1);
  assign last     = (pos_plus >= len);

  always_comb begin
    item.mode         = mode;
    item.overflow     = ovf;
    item.frames_held  = held_now;
    item.flag_missing = miss;
    item.end_of_frame = last;
    if (mode == frq_pkg::MODE_REPLAY) begin
      item.addr = {oldest_slot, pixel_position};
    end else begin
      item.addr = {wslot, pixel_position};
    end
  end

  always_comb begin
    oldest_slot_next    = oldest_slot;
    frames_held_next    = frames_held;
    pixel_position_next = pos_plus[frq_pkg::POS_BITS-1:0];
    if (last) begin
      pixel_position_next = '0;
      if (mode == frq_pkg::MODE_REPLAY || (mode == frq_pkg::MODE_RECORD && ovf)) begin
        oldest_slot_next = oldest_slot + frq_pkg::SLOT_BITS'(1);
      end
      if (mode != frq_pkg::MODE_PASS) begin
        frames_held_next = held_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_frames <= frq_pkg::CAP_RESET;
      frame_pixels    <= frq_pkg::LEN_RESET;
      oldest_slot     <= '0;
      frames_held     <= '0;
      pixel_position  <= '0;
      frame_mode      <= frq_pkg::MODE_PASS;
      ovf_latched     <= 1'b0;
      missing_latched <= 1'b0;
      held_after      <= '0;
      write_slot      <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          frq_pkg::REG_CAPACITY:
            capacity_frames <= cfg_wdata[frq_pkg::HELD_BITS-1:0];
          frq_pkg::REG_FRAME_PIXELS:
            frame_pixels <= cfg_wdata[frq_pkg::LEN_BITS-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        oldest_slot    <= oldest_slot_next;
        frames_held    <= frames_held_next;
        pixel_position <= pixel_position_next;
        if (start) begin
          ovf_latched     <= s_ovf;
          missing_latched <= s_miss;
          held_after      <= s_held;
          write_slot      <= s_wslot;
        end
        frame_mode <= last ? frq_pkg::MODE_PASS : mode;
      end
    end
  end

endmodule

// ----- rtl/frame_record_replay_queue.sv -----
// Top level of the frame record/replay queue: control, frame store and output register.
//
// Pixels enter on in_valid/in_ready with record_flag and flag_present; the flags
// are looked at only on the first pixel of each frame and fix that frame's mode.
// Results leave on out_valid/out_ready, one per request, in order.
// Each accepted request's result is captured in the output register.
// Throughput: one pixel per cycle unless the receiver stalls; each recorded or replayed
// pixel takes one access of the single-port frame store (a write when recording, a read when replaying).
// The output register holds its result while out_ready is low; in_ready follows
// out_ready when a result is waiting, so a stalled receiver stalls the source
// without losing or repeating a request.
// Configuration: cfg_wr_en with cfg_index 0 (capacity_frames) or 1 (frame_pixels)
// writes cfg_wdata at once. Capacity changes take effect at the next frame start.
// Reset clears the ring (no frames held), the pixel position and the output valid;
// config returns to capacity 50 and 4096 pixels per frame. The frame store is not
// cleared and needs no sweep: a slot is always written before it is replayed.
module frame_record_replay_queue (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic                              cfg_index,
  input  logic [frq_pkg::CFG_BITS-1:0]      cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [frq_pkg::PIXEL_BITS-1:0]    pixel_in,
  input  logic                              record_flag,
  input  logic                              flag_present,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [frq_pkg::PIXEL_BITS-1:0]    pixel_out,
  output logic                              overflow,
  output logic [frq_pkg::HELD_BITS-1:0]     frames_held_out,
  output logic                              flag_missing,
  output logic                              end_of_frame
);

  logic                           accept;
  frq_pkg::frq_item_t             item;
  logic [frq_pkg::PIXEL_BITS-1:0] rd_data;
  logic [frq_pkg::PIXEL_BITS-1:0] out_pixel;
  logic                           out_replay;
  logic                           out_ovf, out_miss, out_eof;
  logic [frq_pkg::HELD_BITS-1:0]  out_held;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  frq_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .accept       (accept),
    .record_flag  (record_flag),
    .flag_present (flag_present),
    .item         (item)
  );

  frq_store u_store (
    .clk   (clk),
    .en    (accept && item.mode != frq_pkg::MODE_PASS),
    .we    (item.mode == frq_pkg::MODE_RECORD),
    .addr  (item.addr),
    .wdata (pixel_in),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_pixel  <= pixel_in;
      out_replay <= (item.mode == frq_pkg::MODE_REPLAY);
      out_ovf    <= item.overflow;
      out_held   <= item.frames_held;
      out_miss   <= item.flag_missing;
      out_eof    <= item.end_of_frame;
    end
  end

  // store read data stays put until the next request, so it is valid while stalled
  assign pixel_out       = out_replay ? rd_data : out_pixel;
  assign overflow        = out_ovf;
  assign frames_held_out = out_held;
  assign flag_missing    = out_miss;
  assign end_of_frame    = out_eof;

endmodule
